FILE: rtl/per_line_row_scroll_recorder_core_macros.svh
// assertion macros for the checker file of the row-scroll recorder
// no dependencies; include by bare file name
`ifndef PER_LINE_ROW_SCROLL_RECORDER_CORE_MACROS_SVH
`define PER_LINE_ROW_SCROLL_RECORDER_CORE_MACROS_SVH

// property checked on every rising clock edge outside reset
`define PRSR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define PRSR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `PRSR_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

FILE: rtl/prsr_pkg.sv
// shared types, constants and the x/y scroll bit scramble of the row-scroll recorder
// no dependencies
`timescale 1ns / 1ps

package prsr_pkg;

  localparam int unsigned LinesDef = 256;
  localparam int unsigned RegWords = 64;
  localparam int unsigned ScrollW  = 9;

  typedef enum logic [1:0] {
    ModeRegWrite = 2'd0,
    ModeEndFrame = 2'd1,
    ModeQuery    = 2'd2
  } prsr_mode_e;

  // word indexes of the scroll registers that matter
  localparam logic [5:0] IdxBackXHi = 6'h05;
  localparam logic [5:0] IdxBackXLo = 6'h06;
  localparam logic [5:0] IdxBackYHi = 6'h0d;
  localparam logic [5:0] IdxBackYLo = 6'h0e;
  localparam logic [5:0] IdxForeXHi = 6'h15;
  localparam logic [5:0] IdxForeXLo = 6'h16;
  localparam logic [5:0] IdxForeYHi = 6'h1d;
  localparam logic [5:0] IdxForeYLo = 6'h1e;
  localparam logic [5:0] IdxPrio    = 6'h28;

  typedef struct packed {
    logic [ScrollW-1:0] back_x;
    logic [ScrollW-1:0] fore_x;
    logic [ScrollW-1:0] back_y;
    logic [ScrollW-1:0] fore_y;
    logic               back_on_bottom;
  } prsr_scroll_t;

  typedef struct packed {
    logic rec;
    logic eof;
    logic query;
  } prsr_tbl_ctl_t;

  // bit 4 of the high word on top, low byte rotated left by one
  function automatic logic [ScrollW-1:0] scramble(input logic hi_bit, input logic [7:0] lo);
    return {hi_bit, lo[6:0], lo[7]};
  endfunction

endpackage

FILE: rtl/prsr_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module prsr_ram #(
  parameter int unsigned Width = 9,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // read during write returns the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/prsr_regs.sv
// scroll register file: keeps the bits of the scroll words that are read
// depends on prsr_pkg
`timescale 1ns / 1ps

module prsr_regs (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   wr_en_i,
  input  logic [5:0]             idx_i,
  input  logic [15:0]            data_i,
  output prsr_pkg::prsr_scroll_t scroll_o
);
  import prsr_pkg::*;

  logic [9:0] idx_ext;
  logic [5:0] widx;

  logic       bxh_q, bxh_d, byh_q, byh_d, fxh_q, fxh_d, fyh_q, fyh_d, prio_q, prio_d;
  logic [7:0] bxl_q, bxl_d, byl_q, byl_d, fxl_q, fxl_d, fyl_q, fyl_d;

  // index wraps at the register file size
  assign idx_ext = {4'b0, idx_i};
  assign widx = (idx_ext >= 10'(RegWords)) ? 6'(idx_ext - 10'(RegWords)) : idx_i;

  always_comb begin
    bxh_d  = bxh_q;
    bxl_d  = bxl_q;
    byh_d  = byh_q;
    byl_d  = byl_q;
    fxh_d  = fxh_q;
    fxl_d  = fxl_q;
    fyh_d  = fyh_q;
    fyl_d  = fyl_q;
    prio_d = prio_q;
    if (wr_en_i) begin
      case (widx)
        IdxBackXHi: bxh_d  = data_i[4];
        IdxBackXLo: bxl_d  = data_i[7:0];
        IdxBackYHi: byh_d  = data_i[4];
        IdxBackYLo: byl_d  = data_i[7:0];
        IdxForeXHi: fxh_d  = data_i[4];
        IdxForeXLo: fxl_d  = data_i[7:0];
        IdxForeYHi: fyh_d  = data_i[4];
        IdxForeYLo: fyl_d  = data_i[7:0];
        IdxPrio:    prio_d = data_i[8];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bxh_q  <= 1'b0;
      bxl_q  <= '0;
      byh_q  <= 1'b0;
      byl_q  <= '0;
      fxh_q  <= 1'b0;
      fxl_q  <= '0;
      fyh_q  <= 1'b0;
      fyl_q  <= '0;
      prio_q <= 1'b0;
    end else begin
      bxh_q  <= bxh_d;
      bxl_q  <= bxl_d;
      byh_q  <= byh_d;
      byl_q  <= byl_d;
      fxh_q  <= fxh_d;
      fxl_q  <= fxl_d;
      fyh_q  <= fyh_d;
      fyl_q  <= fyl_d;
      prio_q <= prio_d;
    end
  end

  // views include the word being written this cycle
  assign scroll_o.back_x         = scramble(bxh_d, bxl_d);
  assign scroll_o.fore_x         = scramble(fxh_d, fxl_d);
  assign scroll_o.back_y         = scramble(byh_d, byl_d);
  assign scroll_o.fore_y         = scramble(fyh_d, fyl_d);
  assign scroll_o.back_on_bottom = prio_d;

endmodule

FILE: rtl/prsr_line_tbl.sv
// per-line x scroll table of one layer with valid marks and the carry-forward latch
// depends on prsr_pkg and prsr_ram
`timescale 1ns / 1ps

module prsr_line_tbl #(
  parameter int unsigned Lines = prsr_pkg::LinesDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [$clog2(Lines)-1:0]         rd_addr_i,
  input  prsr_pkg::prsr_tbl_ctl_t          ctl_i,
  input  logic [$clog2(Lines)-1:0]         addr_i,
  input  logic [prsr_pkg::ScrollW-1:0]     wdata_i,
  output logic [prsr_pkg::ScrollW-1:0]     xscroll_o
);
  import prsr_pkg::*;

  localparam int unsigned LineW = $clog2(Lines);

  logic                 we;
  logic [LineW-1:0]     waddr;
  logic [ScrollW-1:0]   ram_rdata;
  logic                 fwd_vld_q;
  logic [LineW-1:0]     fwd_addr_q;
  logic [ScrollW-1:0]   fwd_data_q;
  logic [Lines-1:0]     valid_q;
  logic [Lines-1:0]     written_q;
  logic [ScrollW-1:0]   latch_q, latch_d;
  logic [ScrollW-1:0]   entry;

  assign we    = ctl_i.rec | ctl_i.eof;
  assign waddr = ctl_i.eof ? '0 : addr_i;

  prsr_ram #(
    .Width(ScrollW),
    .Depth(Lines)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata_i),
    .raddr_i(rd_addr_i),
    .rdata_o(ram_rdata)
  );

  // the read was issued on the edge of last cycle's write: forward it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_vld_q <= 1'b0;
    end else begin
      fwd_vld_q <= we;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_addr_q <= waddr;
    fwd_data_q <= wdata_i;
  end

  // entries never written since reset read as zero
  always_comb begin
    entry = '0;
    if (written_q[addr_i]) begin
      entry = (fwd_vld_q && fwd_addr_q == addr_i) ? fwd_data_q : ram_rdata;
    end
    latch_d = latch_q;
    if (ctl_i.query && (addr_i == '0 || valid_q[addr_i])) begin
      latch_d = entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '1;
      written_q <= '0;
      latch_q   <= '0;
    end else begin
      latch_q <= latch_d;
      if (ctl_i.eof) begin
        valid_q      <= {{(Lines-1){1'b0}}, 1'b1};
        written_q[0] <= 1'b1;
      end else if (ctl_i.rec) begin
        valid_q[addr_i]   <= 1'b1;
        written_q[addr_i] <= 1'b1;
      end
    end
  end

  assign xscroll_o = latch_d;

endmodule

FILE: rtl/per_line_row_scroll_recorder_core.sv
// top level of the per-line row-scroll recorder
// depends on prsr_pkg, prsr_regs, prsr_line_tbl
`timescale 1ns / 1ps

// Command channel: a transaction is taken on each rising edge with start_i high
// and busy_o low. busy_o is always low, so one transaction can be taken every
// cycle. mode_i selects a scroll register write, an end of frame or a line
// query; only a query produces a result.
// Result channel: valid_o is high for exactly one cycle with the result fields;
// the receiver cannot stall it. A query passes the input register, then the
// result register, before its result is shown.
// Throughput is one transaction per cycle; the line tables are block rams read
// from the input side, so the read overlaps the input register and a same-cycle
// write is forwarded.
// Reset clears the scroll registers, the latches and the line tables (all lines
// valid with zero scroll) at once; no clearing sweep is needed, and the block
// takes transactions in the first cycle after reset.
module per_line_row_scroll_recorder_core #(
  parameter int unsigned Lines = prsr_pkg::LinesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [1:0]                   mode_i,
  input  logic [5:0]                   reg_index_i,
  input  logic [15:0]                  reg_data_i,
  input  logic [7:0]                   line_i,
  output logic                         valid_o,
  output logic [prsr_pkg::ScrollW-1:0] back_row_o,
  output logic [prsr_pkg::ScrollW-1:0] back_xscroll_o,
  output logic [prsr_pkg::ScrollW-1:0] back_yscroll_o,
  output logic [prsr_pkg::ScrollW-1:0] fore_row_o,
  output logic [prsr_pkg::ScrollW-1:0] fore_xscroll_o,
  output logic [prsr_pkg::ScrollW-1:0] fore_yscroll_o,
  output logic                         back_on_bottom_o
);
  import prsr_pkg::*;

  localparam int unsigned LineW = $clog2(Lines);

  logic [LineW-1:0]   line_map [256];
  logic               accept;
  logic               s1_vld_q;
  prsr_mode_e         s1_mode_q;
  logic [5:0]         s1_idx_q;
  logic [15:0]        s1_data_q;
  logic [7:0]         s1_line_q;
  logic [LineW-1:0]   s1_li_q;
  logic               s1_wr, s1_eof, s1_query;
  prsr_scroll_t       scroll;
  prsr_tbl_ctl_t      back_ctl, fore_ctl;
  logic [ScrollW-1:0] back_x, fore_x;

  logic               out_vld_q;
  logic [ScrollW-1:0] back_row_q, back_x_q, back_y_q, fore_row_q, fore_x_q, fore_y_q;
  logic               bob_q;

  // scanline to table entry, wrapping at the table depth
  for (genvar g = 0; g < 256; g++) begin : g_line_map
    assign line_map[g] = LineW'(g % Lines);
  end

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_mode_q <= prsr_mode_e'(mode_i);
      s1_idx_q  <= reg_index_i;
      s1_data_q <= reg_data_i;
      s1_line_q <= line_i;
      s1_li_q   <= line_map[line_i];
    end
  end

  always_comb begin
    s1_wr    = 1'b0;
    s1_eof   = 1'b0;
    s1_query = 1'b0;
    case (s1_mode_q)
      ModeRegWrite: s1_wr    = s1_vld_q;
      ModeEndFrame: s1_eof   = s1_vld_q;
      ModeQuery:    s1_query = s1_vld_q;
      default:      ;
    endcase
  end

  prsr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (s1_wr),
    .idx_i   (s1_idx_q),
    .data_i  (s1_data_q),
    .scroll_o(scroll)
  );

  // recording compares the raw index, before wrapping
  assign back_ctl.rec   = s1_wr && (s1_idx_q == IdxBackXHi || s1_idx_q == IdxBackXLo);
  assign back_ctl.eof   = s1_eof;
  assign back_ctl.query = s1_query;
  assign fore_ctl.rec   = s1_wr && (s1_idx_q == IdxForeXHi || s1_idx_q == IdxForeXLo);
  assign fore_ctl.eof   = s1_eof;
  assign fore_ctl.query = s1_query;

  prsr_line_tbl #(.Lines(Lines)) u_back_tbl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_addr_i(line_map[line_i]),
    .ctl_i    (back_ctl),
    .addr_i   (s1_li_q),
    .wdata_i  (scroll.back_x),
    .xscroll_o(back_x)
  );

  prsr_line_tbl #(.Lines(Lines)) u_fore_tbl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_addr_i(line_map[line_i]),
    .ctl_i    (fore_ctl),
    .addr_i   (s1_li_q),
    .wdata_i  (scroll.fore_x),
    .xscroll_o(fore_x)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= s1_query;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_query) begin
      back_row_q <= {1'b0, s1_line_q} + scroll.back_y;
      back_x_q   <= back_x;
      back_y_q   <= scroll.back_y;
      fore_row_q <= {1'b0, s1_line_q} + scroll.fore_y;
      fore_x_q   <= fore_x;
      fore_y_q   <= scroll.fore_y;
      bob_q      <= scroll.back_on_bottom;
    end
  end

  assign valid_o          = out_vld_q;
  assign back_row_o       = back_row_q;
  assign back_xscroll_o   = back_x_q;
  assign back_yscroll_o   = back_y_q;
  assign fore_row_o       = fore_row_q;
  assign fore_xscroll_o   = fore_x_q;
  assign fore_yscroll_o   = fore_y_q;
  assign back_on_bottom_o = bob_q;

endmodule

FILE: rtl/prsr_chk.sv
// port-level checker for the row-scroll recorder, bound to the top level
// depends on prsr_pkg and per_line_row_scroll_recorder_core_macros.svh
`timescale 1ns / 1ps
`include "per_line_row_scroll_recorder_core_macros.svh"

module prsr_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start_i,
  input logic                         busy_o,
  input logic [1:0]                   mode_i,
  input logic [7:0]                   line_i,
  input logic                         valid_o,
  input logic [prsr_pkg::ScrollW-1:0] back_row_o,
  input logic [prsr_pkg::ScrollW-1:0] back_yscroll_o,
  input logic [prsr_pkg::ScrollW-1:0] fore_row_o,
  input logic [prsr_pkg::ScrollW-1:0] fore_yscroll_o
);
  import prsr_pkg::*;

  logic query_acc;

  assign query_acc = start_i && !busy_o && mode_i == ModeQuery;

  // every result comes from an accepted query, and every query gives one
  `PRSR_ASSERT(a_res_from_query, clk_i, rst_ni, valid_o |-> $past(query_acc, 2), "result without query")
  `PRSR_ASSERT(a_query_gives_res, clk_i, rst_ni, query_acc |-> ##2 valid_o, "query without result")
  // rows are the queried line plus the reported y scroll
  `PRSR_ASSERT(a_back_row, clk_i, rst_ni,
    valid_o |-> back_row_o == 9'({1'b0, $past(line_i, 2)} + back_yscroll_o), "back row mismatch")
  `PRSR_ASSERT(a_fore_row, clk_i, rst_ni,
    valid_o |-> fore_row_o == 9'({1'b0, $past(line_i, 2)} + fore_yscroll_o), "fore row mismatch")

endmodule

bind per_line_row_scroll_recorder_core prsr_chk u_prsr_chk (.*);
